>>> src/sfc_pkg.sv
// Shared types, codes and helpers for the four-plane sphere culling block.
package sfc_pkg;

   localparam int NPLANES = 4;

   localparam logic [2:0] REG_ROW0_XY = 3'd0;
   localparam logic [2:0] REG_ROW0_ZW = 3'd1;
   localparam logic [2:0] REG_ROW2_XY = 3'd2;
   localparam logic [2:0] REG_ROW2_ZW = 3'd3;
   localparam logic [2:0] REG_ROW3_XY = 3'd4;
   localparam logic [2:0] REG_ROW3_ZW = 3'd5;
   localparam logic [2:0] REG_EPSILON = 3'd6;

   localparam logic [2:0] CULL_NONE  = 3'd0;
   localparam logic [2:0] CULL_LEFT  = 3'd1;
   localparam logic [2:0] CULL_RIGHT = 3'd2;
   localparam logic [2:0] CULL_NEAR  = 3'd3;
   localparam logic [2:0] CULL_FAR   = 3'd4;

   localparam logic [15:0] EPSILON_RESET = 16'd7;

   typedef struct packed {
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
      logic signed [31:0] w;
   } plane_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] rad;
      logic [2:0]         culled;
   } sphere_type;

   function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic sub);
      logic signed [32:0] s;
      begin
         s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
         if (s[32] != s[31]) begin
            sat_sum = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            sat_sum = s[31:0];
         end
      end
   endfunction

   function automatic logic signed [31:0] word_sel(input logic [63:0] xy,
                                                   input logic [63:0] zw,
                                                   input logic [1:0] c);
      begin
         case (c)
            2'd0: word_sel = xy[31:0];
            2'd1: word_sel = xy[63:32];
            2'd2: word_sel = zw[31:0];
            default: word_sel = zw[63:32];
         endcase
      end
   endfunction

endpackage

>>> src/sfc_plane_build.sv
// Sequencer that derives and normalizes the four planes with an iterative root and divider.
module sfc_plane_build (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [63:0]                       row0_xy,
   input  logic [63:0]                       row0_zw,
   input  logic [63:0]                       row2_xy,
   input  logic [63:0]                       row2_zw,
   input  logic [63:0]                       row3_xy,
   input  logic [63:0]                       row3_zw,
   input  logic [15:0]                       epsilon,
   output logic                              busy,
   output sfc_pkg::plane_type [3:0]          planes
);
   import sfc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_DIVI = 3'd5;
   localparam logic [2:0] ST_DIV  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  p_ff, p_in, c_ff, c_in;
   logic [63:0] sq_ff, sq_in, len2_ff, len2_in, src_ff, src_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] q_ff, q_in;
   logic [32:0] drem_ff, drem_in;
   logic        neg_ff, neg_in;
   plane_type [3:0] plane_ff, plane_in;

   logic signed [31:0] raw, other;
   logic [32:0] neg33;
   logic [31:0] mag;
   logic [35:0] remsh;
   logic [33:0] trial, dt;
   logic [47:0] qf;
   logic [31:0] res;

   always_comb begin
      other = p_ff[1] ? word_sel(row2_xy, row2_zw, c_ff) : word_sel(row0_xy, row0_zw, c_ff);
      raw   = sat_sum(word_sel(row3_xy, row3_zw, c_ff), other, p_ff[0] ^ p_ff[1]);
      neg33 = -{raw[31], raw};
      mag   = raw[31] ? neg33[31:0] : raw;
   end

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      c_in     = c_ff;
      sq_in    = sq_ff;
      len2_in  = len2_ff;
      src_in   = src_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      drem_in  = drem_ff;
      neg_in   = neg_ff;
      plane_in = plane_ff;
      remsh    = {rem_ff[33:0], src_ff[63:62]};
      trial    = {root_ff, 2'b01};
      dt       = {drem_ff, q_ff[47]};
      qf       = q_ff;
      res      = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SQ: begin
            sq_in    = {32'b0, mag} * {32'b0, mag};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            len2_in = len2_ff + sq_ff;
            if (c_ff == 2'd2) begin
               c_in     = 2'd0;
               state_in = ST_CHK;
            end else begin
               c_in     = c_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         ST_CHK: begin
            if (len2_ff == 64'd0 || len2_ff < {32'b0, epsilon, 16'b0}) begin
               plane_in[p_ff] = '0;
               len2_in = '0;
               c_in    = 2'd0;
               if (p_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  p_in     = p_ff + 2'd1;
                  state_in = ST_SQ;
               end
            end else begin
               src_in   = len2_ff;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (remsh >= {2'b0, trial}) begin
               rem_in  = remsh - {2'b0, trial};
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = remsh;
               root_in = {root_ff[30:0], 1'b0};
            end
            src_in = {src_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               c_in     = 2'd0;
               state_in = ST_DIVI;
            end
         end
         ST_DIVI: begin
            q_in     = {mag, 16'b0};
            drem_in  = '0;
            neg_in   = raw[31];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dt >= {2'b0, root_ff}) begin
               drem_in = 33'(dt - {2'b0, root_ff});
               qf      = {q_ff[46:0], 1'b1};
            end else begin
               drem_in = dt[32:0];
               qf      = {q_ff[46:0], 1'b0};
            end
            q_in   = qf;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               if (qf[47:31] != '0) begin
                  res = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  res = neg_ff ? 32'(-qf[31:0]) : qf[31:0];
               end
               case (c_ff)
                  2'd0: plane_in[p_ff].nx = res[17:0];
                  2'd1: plane_in[p_ff].ny = res[17:0];
                  2'd2: plane_in[p_ff].nz = res[17:0];
                  default: plane_in[p_ff].w = res;
               endcase
               if (c_ff == 2'd3) begin
                  len2_in = '0;
                  c_in    = 2'd0;
                  if (p_ff == 2'd3) begin
                     state_in = ST_IDLE;
                  end else begin
                     p_in     = p_ff + 2'd1;
                     state_in = ST_SQ;
                  end
               end else begin
                  c_in     = c_ff + 2'd1;
                  state_in = ST_DIVI;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (start) begin
         state_in = ST_SQ;
         p_in     = 2'd0;
         c_in     = 2'd0;
         len2_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SQ;
         p_ff     <= 2'd0;
         c_ff     <= 2'd0;
         len2_ff  <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         c_ff     <= c_in;
         len2_ff  <= len2_in;
      end
      sq_ff    <= sq_in;
      src_ff   <= src_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      q_ff     <= q_in;
      drem_ff  <= drem_in;
      neg_ff   <= neg_in;
      plane_ff <= plane_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign planes = plane_ff;

endmodule

>>> src/sfc_cull_cell.sv
// One plane test cell: products in the first stage, sum and compare in the second.
module sfc_cull_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sfc_pkg::plane_type    plane,
   input  logic [2:0]            code,
   input  logic [15:0]           epsilon,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sfc_pkg::sphere_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sfc_pkg::sphere_type   out_item
);
   import sfc_pkg::*;

   logic               a_vld_ff, b_vld_ff, ld_a, ld_b;
   sphere_type         a_item_ff, b_item_ff, b_item_in;
   logic signed [49:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [51:0] s, lim;

   assign ld_b     = a_vld_ff && (!b_vld_ff || out_ready);
   assign in_ready = !a_vld_ff || ld_b;
   assign ld_a     = in_valid && in_ready;

   always_comb begin
      px_in = plane.nx * in_item.cx;
      py_in = plane.ny * in_item.cy;
      pz_in = plane.nz * in_item.cz;
      s = 52'(px_ff) + 52'(py_ff) + 52'(pz_ff)
        + 52'($signed({plane.w, 16'b0})) + 52'($signed({a_item_ff.rad, 16'b0}));
      lim = s + $signed({20'b0, epsilon, 16'b0});
      b_item_in = a_item_ff;
      if (a_item_ff.culled == CULL_NONE && lim[51]) begin
         b_item_in.culled = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (ld_a) begin
            a_vld_ff <= 1'b1;
         end else if (ld_b) begin
            a_vld_ff <= 1'b0;
         end
         if (ld_b) begin
            b_vld_ff <= 1'b1;
         end else if (out_ready) begin
            b_vld_ff <= 1'b0;
         end
      end
      if (ld_a) begin
         a_item_ff <= in_item;
         px_ff     <= px_in;
         py_ff     <= py_in;
         pz_ff     <= pz_in;
      end
      if (ld_b) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_item  = b_item_ff;

endmodule

>>> src/sphere_frustum_cull_four_planes.sv
// Top level: configuration registers, plane builder and a chain of four plane test cells.
// Usage: write the matrix rows and epsilon over the csr_ port (64-bit registers at
// byte address 8*i). Every write, and reset itself, starts a rebuild of the four
// normalized planes; req_tready stays low until it finishes. A rebuild runs the
// bit-serial square root (32 steps per plane) and the bit-serial divider (48 steps
// per component) shared by all sixteen components. Spheres enter on req_ (tdata:
// center_x, center_y, center_z, radius) and results leave on rsp_ (tdata: visible,
// culled_by). Once planes are built, one sphere is taken every cycle while the
// receiver keeps up; each sphere passes through the left, right, near and far cells,
// two register stages each, plus the output register. Every stage holds its own
// item, so while the receiver stalls the chain keeps filling until all stages are
// full, and resumes at full rate when rsp_tready returns. Reset empties the chain
// and restores the register defaults.
module sphere_frustum_cull_four_planes (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // center_x, center_y, center_z, radius
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // visible, culled_by, zero fill
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import sfc_pkg::*;

   logic [63:0] row0_xy_ff, row0_zw_ff, row2_xy_ff, row2_zw_ff, row3_xy_ff, row3_zw_ff;
   logic [15:0] epsilon_ff;
   logic        wr, busy;
   plane_type [3:0] planes;
   logic [2:0]  codes [NPLANES];
   logic        vld [NPLANES+1];
   logic        rdy [NPLANES+1];
   sphere_type  item [NPLANES+1];
   logic        rsp_vld_ff;
   logic [2:0]  rsp_cull_ff;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_xy_ff <= '0;
         row0_zw_ff <= '0;
         row2_xy_ff <= '0;
         row2_zw_ff <= '0;
         row3_xy_ff <= '0;
         row3_zw_ff <= '0;
         epsilon_ff <= EPSILON_RESET;
      end else if (wr) begin
         unique case (csr_paddr[5:3])
            REG_ROW0_XY: row0_xy_ff <= csr_pwdata;
            REG_ROW0_ZW: row0_zw_ff <= csr_pwdata;
            REG_ROW2_XY: row2_xy_ff <= csr_pwdata;
            REG_ROW2_ZW: row2_zw_ff <= csr_pwdata;
            REG_ROW3_XY: row3_xy_ff <= csr_pwdata;
            REG_ROW3_ZW: row3_zw_ff <= csr_pwdata;
            REG_EPSILON: epsilon_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_ROW0_XY: csr_prdata = row0_xy_ff;
         REG_ROW0_ZW: csr_prdata = row0_zw_ff;
         REG_ROW2_XY: csr_prdata = row2_xy_ff;
         REG_ROW2_ZW: csr_prdata = row2_zw_ff;
         REG_ROW3_XY: csr_prdata = row3_xy_ff;
         REG_ROW3_ZW: csr_prdata = row3_zw_ff;
         REG_EPSILON: csr_prdata = {48'b0, epsilon_ff};
         default:     csr_prdata = '0;
      endcase
   end

   sfc_plane_build u_build (
      .clock   (clock),
      .reset   (reset),
      .start   (wr),
      .row0_xy (row0_xy_ff),
      .row0_zw (row0_zw_ff),
      .row2_xy (row2_xy_ff),
      .row2_zw (row2_zw_ff),
      .row3_xy (row3_xy_ff),
      .row3_zw (row3_zw_ff),
      .epsilon (epsilon_ff),
      .busy    (busy),
      .planes  (planes)
   );

   assign codes[0] = CULL_LEFT;
   assign codes[1] = CULL_RIGHT;
   assign codes[2] = CULL_NEAR;
   assign codes[3] = CULL_FAR;

   assign vld[0]         = req_tvalid && !busy;
   assign req_tready     = rdy[0] && !busy;
   assign item[0].cx     = req_tdata[31:0];
   assign item[0].cy     = req_tdata[63:32];
   assign item[0].cz     = req_tdata[95:64];
   assign item[0].rad    = req_tdata[127:96];
   assign item[0].culled = CULL_NONE;

   for (genvar i = 0; i < NPLANES; i++) begin : g_cell
      sfc_cull_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (planes[i]),
         .code      (codes[i]),
         .epsilon   (epsilon_ff),
         .in_valid  (vld[i]),
         .in_ready  (rdy[i]),
         .in_item   (item[i]),
         .out_valid (vld[i+1]),
         .out_ready (rdy[i+1]),
         .out_item  (item[i+1])
      );
   end

   assign rdy[NPLANES] = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rdy[NPLANES]) begin
         rsp_vld_ff <= vld[NPLANES];
      end
      if (rdy[NPLANES] && vld[NPLANES]) begin
         rsp_cull_ff <= item[NPLANES].culled;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, rsp_cull_ff, (rsp_cull_ff == CULL_NONE)};

endmodule

>>> src/sfc_checker.sv
// Port-level checks for the culling block, attached to the top level by bind.
module sfc_port_assert (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite
);
   import sfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == CULL_NONE)))
      else $error("visible flag disagrees with culling plane");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] <= CULL_FAR))
      else $error("culling plane code out of range");

   a_reset_build: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken before planes were rebuilt after reset");

   a_write_build: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_tready)
      else $error("item taken before planes were rebuilt after a write");

endmodule

bind sphere_frustum_cull_four_planes sfc_port_assert u_sfc_port_assert (.*);
